### hdl/pwsf_pkg.sv
// shared types and constants for the poly-t window start finder
package pwsf_pkg;

  // ascii code of an uppercase t
  localparam logic [7:0] T_CHAR = 8'd84;

  // length of the t run searched for inside the chosen window
  localparam int RUN_LEN = 3;

  // default largest window the history holds
  localparam int MAX_WINDOW_DEF = 64;

  // field widths
  localparam int BASE_W = 8;
  localparam int IDX_W  = 16;
  localparam int POS_W  = 17;
  localparam int REG_W  = 7;

  // configuration register indexes
  localparam logic REG_WINDOW_LENGTH   = 1'b0;
  localparam logic REG_MIN_T_IN_WINDOW = 1'b1;

  // register reset values
  localparam logic [REG_W-1:0] WINDOW_LENGTH_RST   = 7'd16;
  localparam logic [REG_W-1:0] MIN_T_IN_WINDOW_RST = 7'd12;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  // classified base as it travels from front to back
  typedef struct packed {
    logic             tflag;
    logic [IDX_W-1:0] idx;
    logic             last;
  } item_t;

  // back end sequencer states
  typedef enum logic {
    BK_RUN,
    BK_RECOUNT
  } back_state_t;

endpackage

### hdl/polyt_window_start_finder.sv
// top level of the poly-t window start finder
//
// in_ channel: one base per transfer; in_tdata holds base[7:0] and
// base_index[23:8], in_tlast marks the final base of a stream.
// out_ channel: one transfer per stream, after its final base; out_tdata
// holds found[0] and polyt_position[17:1].
// cfg_ port: cfg_we writes cfg_wdata into register cfg_addr
// (0 window_length, 1 min_t_in_window) at the clock edge.
// Throughput is one base per cycle outside recounts and result stalls: the
// window count is updated in place and the oldest run of three ts is found
// by a priority search over the history. With the queue empty, the final
// base passes the queue and then the output register before out_tvalid rises.
// After a window_length write the back end recounts its history over the
// clamped window length (3 to MAX_WINDOW); bases keep queueing.
// When the receiver stalls, the result waits in the output register, the
// back end keeps taking bases until it meets the next final base, and the
// four-entry queue then fills before in_tready drops.
// rst_n (synchronous, active low) clears stream state, queue and the result
// valid flag, and restores the register defaults 16 and 12.
module polyt_window_start_finder #(
  parameter int MAX_WINDOW = pwsf_pkg::MAX_WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // base[7:0], base_index[23:8]
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [23:0]                out_tdata,  // found[0], polyt_position[17:1]
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [pwsf_pkg::REG_W-1:0] cfg_wdata
);

  logic [pwsf_pkg::REG_W-1:0] window_length_r;
  logic [pwsf_pkg::REG_W-1:0] min_t_in_window_r;
  logic                       recount_start;
  logic                       queue_full;
  logic                       push;
  pwsf_pkg::item_t            push_item;
  logic                       pop;
  logic                       fifo_valid;
  pwsf_pkg::item_t            fifo_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r   <= pwsf_pkg::WINDOW_LENGTH_RST;
      min_t_in_window_r <= pwsf_pkg::MIN_T_IN_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pwsf_pkg::REG_WINDOW_LENGTH:   window_length_r   <= cfg_wdata;
        pwsf_pkg::REG_MIN_T_IN_WINDOW: min_t_in_window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign recount_start = cfg_we && (cfg_addr == pwsf_pkg::REG_WINDOW_LENGTH);

  // front end
  pwsf_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // queue between front and back
  pwsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .valid     (fifo_valid),
    .head      (fifo_item)
  );

  // back end
  pwsf_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .window_length   (window_length_r),
    .min_t_in_window (min_t_in_window_r),
    .recount_start   (recount_start),
    .fifo_valid      (fifo_valid),
    .fifo_item       (fifo_item),
    .pop             (pop),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata)
  );

endmodule

### hdl/pwsf_front.sv
// front end: takes base transfers, classifies each base as t or not
module pwsf_front (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // base[7:0], base_index[23:8]
  input  logic                 in_tlast,
  input  logic                 queue_full,
  output logic                 push,
  output pwsf_pkg::item_t      push_item
);

  logic [pwsf_pkg::BASE_W-1:0] base;
  logic [pwsf_pkg::IDX_W-1:0]  base_index;

  // unpack the payload
  assign base       = in_tdata[pwsf_pkg::BASE_W-1:0];
  assign base_index = in_tdata[pwsf_pkg::BASE_W +: pwsf_pkg::IDX_W];

  // accept whenever the queue has room
  assign in_tready = !queue_full;
  assign push      = in_tvalid && in_tready;

  // classify and hand on
  always_comb begin
    push_item.tflag = (base == pwsf_pkg::T_CHAR);
    push_item.idx   = base_index;
    push_item.last  = in_tlast;
  end

endmodule

### hdl/pwsf_queue.sv
// short queue that decouples the front end from the back end
module pwsf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pwsf_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            valid,
  output pwsf_pkg::item_t head
);

  localparam int PW = pwsf_pkg::QUEUE_PTR_W;
  localparam int DEPTH = pwsf_pkg::QUEUE_DEPTH;

  pwsf_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     fill_r;

  assign full  = (fill_r == (PW+1)'(DEPTH));
  assign valid = (fill_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

endmodule

### hdl/pwsf_back.sv
// back end: sliding t window, qualification, run search and result register
module pwsf_back #(
  parameter int MAX_WINDOW = pwsf_pkg::MAX_WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [pwsf_pkg::REG_W-1:0] window_length,
  input  logic [pwsf_pkg::REG_W-1:0] min_t_in_window,
  input  logic                       recount_start,
  input  logic                       fifo_valid,
  input  pwsf_pkg::item_t            fifo_item,
  output logic                       pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [23:0]                out_tdata   // found[0], polyt_position[17:1]
);

  localparam int CLOG = $clog2(MAX_WINDOW + 1);
  localparam int CW   = (CLOG > pwsf_pkg::REG_W) ? CLOG : pwsf_pkg::REG_W;
  localparam int HW   = $clog2(MAX_WINDOW);
  localparam int PW   = pwsf_pkg::POS_W;

  pwsf_pkg::back_state_t state_r, state_nxt;

  logic [MAX_WINDOW-1:0] hist_r, hist_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         seen_r, seen_nxt;
  logic                  done_r, done_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [PW-1:0]         res_pos_r, res_pos_nxt;
  logic [CW-1:0]         sweep_j_r, sweep_j_nxt;
  logic [CW-1:0]         sweep_acc_r, sweep_acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [PW-1:0]         out_pos_r, out_pos_nxt;

  logic [CW-1:0]         wl_ext;
  logic [CW-1:0]         w_eff;
  logic [CW-1:0]         w_last;
  logic [CW-1:0]         run_limit;
  logic [MAX_WINDOW-1:0] hist_step;
  logic [CW-1:0]         cnt_step;
  logic [CW-1:0]         seen_step;
  logic                  leave_bit;
  logic                  qualify;
  logic                  run_any;
  logic [HW-1:0]         run_sel;
  logic [PW-1:0]         run_pos;
  logic                  sweep_bit;

  // effective window length, clamped to the legal range
  assign wl_ext = CW'(window_length);
  always_comb begin
    if (wl_ext < CW'(pwsf_pkg::RUN_LEN)) begin
      w_eff = CW'(pwsf_pkg::RUN_LEN);
    end else if (wl_ext > CW'(MAX_WINDOW)) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = wl_ext;
    end
  end
  assign w_last    = w_eff - 1'b1;
  assign run_limit = w_eff - CW'(pwsf_pkg::RUN_LEN);

  // one window step: shift in the new flag, drop the one leaving the window
  assign hist_step = {hist_r[MAX_WINDOW-2:0], fifo_item.tflag};
  assign leave_bit = hist_r[w_last[HW-1:0]];
  assign cnt_step  = cnt_r + CW'(fifo_item.tflag) - CW'(leave_bit);
  assign seen_step = (seen_r == CW'(MAX_WINDOW)) ? seen_r : seen_r + 1'b1;
  assign qualify   = (seen_step >= w_eff) && (cnt_step >= CW'(min_t_in_window));

  // oldest run of three ts in the window: highest start entry not past the limit
  always_comb begin
    run_any = 1'b0;
    run_sel = '0;
    for (int i = 0; i <= MAX_WINDOW - pwsf_pkg::RUN_LEN; i++) begin
      if (hist_step[i] && hist_step[i+1] && hist_step[i+2] && (CW'(i) <= run_limit)) begin
        run_any = 1'b1;
        run_sel = HW'(i);
      end
    end
  end

  // position just after the run, wrapping at the field width
  assign run_pos = {1'b0, fifo_item.idx} + PW'(1) - PW'(run_sel);

  // history bit visited by the recount sweep
  assign sweep_bit = hist_r[sweep_j_r[HW-1:0]];

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pwsf_pkg::BK_RUN;
      hist_r      <= '0;
      cnt_r       <= '0;
      seen_r      <= '0;
      done_r      <= 1'b0;
      res_found_r <= 1'b0;
      res_pos_r   <= '0;
      sweep_j_r   <= '0;
      sweep_acc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hist_r      <= hist_nxt;
      cnt_r       <= cnt_nxt;
      seen_r      <= seen_nxt;
      done_r      <= done_nxt;
      res_found_r <= res_found_nxt;
      res_pos_r   <= res_pos_nxt;
      sweep_j_r   <= sweep_j_nxt;
      sweep_acc_r <= sweep_acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
  end

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    hist_nxt      = hist_r;
    cnt_nxt       = cnt_r;
    seen_nxt      = seen_r;
    done_nxt      = done_r;
    res_found_nxt = res_found_r;
    res_pos_nxt   = res_pos_r;
    sweep_j_nxt   = sweep_j_r;
    sweep_acc_nxt = sweep_acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    pop           = 1'b0;

    unique case (state_r)
      pwsf_pkg::BK_RUN: begin
        // a final base needs the result register free
        pop = fifo_valid && (!fifo_item.last || !out_valid_r || out_tready);
        if (pop) begin
          if (!done_r) begin
            hist_nxt = hist_step;
            cnt_nxt  = cnt_step;
            seen_nxt = seen_step;
            if (qualify) begin
              done_nxt = 1'b1;
              if (run_any) begin
                res_found_nxt = 1'b1;
                res_pos_nxt   = run_pos;
              end
            end
          end
          // end of stream: load the result and clear the stream state
          if (fifo_item.last) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = res_found_nxt;
            out_pos_nxt   = res_found_nxt ? res_pos_nxt : '0;
            hist_nxt      = '0;
            cnt_nxt       = '0;
            seen_nxt      = '0;
            done_nxt      = 1'b0;
            res_found_nxt = 1'b0;
            res_pos_nxt   = '0;
          end
        end
      end
      pwsf_pkg::BK_RECOUNT: begin
        // rebuild the window count after a new window length
        if (sweep_j_r == w_last) begin
          cnt_nxt   = sweep_acc_r + CW'(sweep_bit);
          state_nxt = pwsf_pkg::BK_RUN;
        end else begin
          sweep_acc_nxt = sweep_acc_r + CW'(sweep_bit);
          sweep_j_nxt   = sweep_j_r + 1'b1;
        end
      end
      default: begin
        state_nxt = pwsf_pkg::BK_RUN;
      end
    endcase

    // a window length write restarts the sweep
    if (recount_start) begin
      state_nxt     = pwsf_pkg::BK_RECOUNT;
      sweep_j_nxt   = '0;
      sweep_acc_nxt = '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(24 - PW - 1){1'b0}}, out_pos_r, out_found_r};

endmodule

### verif/testbench.sv
// self-checking testbench for the poly-t window start finder
`timescale 1ns / 100ps

module testbench;

  // ascii codes used besides the uppercase t
  localparam logic [7:0] CH_A       = 8'd65;
  localparam logic [7:0] CH_C       = 8'd67;
  localparam logic [7:0] CH_G       = 8'd71;
  localparam logic [7:0] CH_T_LOWER = 8'd116;

  // input transfers to send before the stimulus stops
  localparam int ITEM_TARGET   = 1950;
  // quiet cycles before a register write: result path plus a full recount
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    logic                       found;
    logic [pwsf_pkg::POS_W-1:0] pos;
  } polyt_report_t;

  typedef struct {
    logic [pwsf_pkg::BASE_W-1:0] base;
    logic [pwsf_pkg::IDX_W-1:0]  idx;
    logic                        last;
    logic                        typed;
    logic                        found;
    logic [pwsf_pkg::POS_W-1:0]  pos;
  } base_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;
  typedef enum logic [1:0] {ST_DENSE, ST_MIXED, ST_PERIODIC, ST_NOISE} stream_kind_t;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_tvalid  = 1'b0;
  logic [23:0]                in_tdata   = '0;   // base[7:0], base_index[23:8]
  logic                       in_tlast   = 1'b0;
  logic                       out_tready = 1'b0;
  logic                       cfg_we     = 1'b0;
  logic                       cfg_addr   = pwsf_pkg::REG_WINDOW_LENGTH;
  logic [pwsf_pkg::REG_W-1:0] cfg_wdata  = '0;
  wire                        in_tready;
  wire                        out_tvalid;
  wire  [23:0]                out_tdata;         // found[0], polyt_position[17:1]

  // mirror of the block's registers and stream state
  logic [pwsf_pkg::REG_W-1:0]          wlen_reg = pwsf_pkg::WINDOW_LENGTH_RST;
  logic [pwsf_pkg::REG_W-1:0]          tmin_reg = pwsf_pkg::MIN_T_IN_WINDOW_RST;
  logic [pwsf_pkg::MAX_WINDOW_DEF-1:0] t_hist   = '0;   // bit 0 is the newest base
  int unsigned                         hist_fill = 0;
  logic                                window_locked = 1'b0;
  logic                                run_hit = 1'b0;
  logic [pwsf_pkg::POS_W-1:0]          run_pos = '0;

  polyt_report_t reports_due[$];
  base_row_t     directed[$];
  int            faults = 0;
  int            sent_bases = 0;
  int            burst_left = 0;
  rx_mode_t      rx_mode = RX_OPEN;
  logic [6:0]    rx_tick = '0;

  polyt_window_start_finder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // window length as the block applies it
  function automatic int span_of(input logic [pwsf_pkg::REG_W-1:0] wl);
    if (wl < pwsf_pkg::RUN_LEN) return pwsf_pkg::RUN_LEN;
    if (wl > pwsf_pkg::MAX_WINDOW_DEF) return pwsf_pkg::MAX_WINDOW_DEF;
    return int'(wl);
  endfunction

  // advance the window by one base, hand back a report on the final base
  function automatic void track_base(input logic [pwsf_pkg::BASE_W-1:0] b,
                                     input logic [pwsf_pkg::IDX_W-1:0] idx,
                                     input logic last, output logic due,
                                     output polyt_report_t rep);
    int w;
    int cnt;
    int k;
    due = 1'b0;
    rep.found = 1'b0;
    rep.pos = '0;
    if (!window_locked) begin
      w = span_of(wlen_reg);
      t_hist = {t_hist[pwsf_pkg::MAX_WINDOW_DEF-2:0], b == pwsf_pkg::T_CHAR};
      if (hist_fill < pwsf_pkg::MAX_WINDOW_DEF) hist_fill++;
      cnt = 0;
      for (k = 0; k < w; k++) cnt += t_hist[k];
      if (hist_fill >= w && cnt >= int'(tmin_reg)) begin
        window_locked = 1'b1;
        // oldest base of the window first
        for (k = 0; k + pwsf_pkg::RUN_LEN <= w; k++) begin
          if (!run_hit && t_hist[w-1-k] && t_hist[w-2-k] && t_hist[w-3-k]) begin
            run_hit = 1'b1;
            run_pos = pwsf_pkg::POS_W'(int'(idx) - (w - 1) + k + pwsf_pkg::RUN_LEN);
          end
        end
      end
    end
    if (last) begin
      due = 1'b1;
      rep.found = run_hit;
      rep.pos = run_hit ? run_pos : '0;
      t_hist = '0;
      hist_fill = 0;
      window_locked = 1'b0;
      run_hit = 1'b0;
      run_pos = '0;
    end
  endfunction

  function automatic void log_fault(input string msg);
    faults++;
    if (faults <= 10) $display("%s", msg);
  endfunction

  function automatic void add_row(input logic [pwsf_pkg::BASE_W-1:0] b,
                                  input logic [pwsf_pkg::IDX_W-1:0] idx,
                                  input logic last, input logic typed, input logic found,
                                  input logic [pwsf_pkg::POS_W-1:0] pos);
    base_row_t r;
    r.base = b;
    r.idx = idx;
    r.last = last;
    r.typed = typed;
    r.found = found;
    r.pos = pos;
    directed.insert(directed.size(), r);
  endfunction

  // one base transfer, with bursts and random gaps on the sender side
  task automatic send_base(input logic [pwsf_pkg::BASE_W-1:0] b,
                           input logic [pwsf_pkg::IDX_W-1:0] idx,
                           input logic last, input logic typed, input logic found,
                           input logic [pwsf_pkg::POS_W-1:0] pos);
    int gap;
    logic due;
    polyt_report_t rep;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {idx, b};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_bases++;
    track_base(b, idx, last, due, rep);
    if (due) begin
      if (typed) begin
        rep.found = found;
        rep.pos = pos;
      end
      reports_due.insert(reports_due.size(), rep);
    end
  endtask

  // registers change only once the block has drained
  task automatic set_registers(input logic [pwsf_pkg::REG_W-1:0] wl,
                               input logic [pwsf_pkg::REG_W-1:0] mn);
    in_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= pwsf_pkg::REG_WINDOW_LENGTH;
    cfg_wdata <= wl;
    @(posedge clk);
    cfg_addr <= pwsf_pkg::REG_MIN_T_IN_WINDOW;
    cfg_wdata <= mn;
    @(posedge clk);
    cfg_we <= 1'b0;
    wlen_reg = wl;
    tmin_reg = mn;
  endtask

  // one stream of random content, mostly long enough to fill the window
  task automatic send_stream();
    int w;
    int len;
    int pct;
    int per;
    int tcnt;
    int shift;
    int pick;
    int i;
    logic is_t;
    stream_kind_t kind;
    logic [pwsf_pkg::BASE_W-1:0] b;
    logic [pwsf_pkg::IDX_W-1:0] idx;
    w = span_of(wlen_reg);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w) : w + $urandom_range(0, 2 * w);
    pick = $urandom_range(0, 99);
    if (pick < 35) kind = ST_DENSE;
    else if (pick < 60) kind = ST_MIXED;
    else if (pick < 90) kind = ST_PERIODIC;
    else kind = ST_NOISE;
    pct = (kind == ST_DENSE) ? (($urandom_range(0, 1) == 0) ? 100 : $urandom_range(85, 99))
                             : $urandom_range(20, 80);
    per = $urandom_range(3, 5);
    tcnt = $urandom_range(1, per - 1);
    shift = $urandom_range(0, per - 1);
    // start positions near both ends of the index range exercise the wrap
    case ($urandom_range(0, 3))
      0: idx = pwsf_pkg::IDX_W'($urandom_range(0, 70));
      1: idx = pwsf_pkg::IDX_W'(16'hFFFF - $urandom_range(0, 40));
      default: idx = pwsf_pkg::IDX_W'($urandom_range(0, 65535));
    endcase
    for (i = 0; i < len; i++) begin
      case (kind)
        ST_DENSE, ST_MIXED: is_t = $urandom_range(0, 99) < pct;
        ST_PERIODIC: is_t = ((i + shift) % per) < tcnt && $urandom_range(0, 49) != 0;
        default: is_t = 1'b0;
      endcase
      if (is_t) begin
        b = pwsf_pkg::T_CHAR;
      end else if (kind == ST_NOISE) begin
        b = pwsf_pkg::BASE_W'($urandom_range(0, 255));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 2) b = CH_A;
        else if (pick < 4) b = CH_C;
        else if (pick < 6) b = CH_G;
        else if (pick < 7) b = CH_T_LOWER;
        else b = pwsf_pkg::BASE_W'($urandom_range(0, 255));
      end
      // occasional jump in the position sequence
      if ($urandom_range(0, 19) == 0) idx = pwsf_pkg::IDX_W'($urandom_range(0, 65535));
      send_base(b, idx, i == len - 1, 1'b0, 1'b0, '0);
      idx++;
    end
  endtask

  task automatic run_phase();
    int start;
    int n;
    start = sent_bases;
    n = 0;
    while (sent_bases - start < 70 && n < 12) begin
      send_stream();
      n++;
    end
  endtask

  // receiver stalls follow a pattern that changes whenever the 7-bit tick wraps
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (rx_tick == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN: out_tready <= 1'b1;
      RX_COIN: out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= (rx_tick[3:0] == 0);
      default: out_tready <= rx_tick[0];
    endcase
  end

  // compare each result transfer with the oldest report due
  always @(posedge clk) begin
    polyt_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reports_due.size() == 0) begin
        log_fault($sformatf("unexpected result: found=%0b pos=%0d",
                            out_tdata[0], out_tdata[pwsf_pkg::POS_W:1]));
      end else begin
        want = reports_due.pop_front();
        if (out_tdata[0] !== want.found || out_tdata[pwsf_pkg::POS_W:1] !== want.pos)
          log_fault($sformatf("result mismatch: expected found=%0b pos=%0d, got found=%0b pos=%0d",
                              want.found, want.pos, out_tdata[0],
                              out_tdata[pwsf_pkg::POS_W:1]));
      end
    end
  end

  initial begin
    logic [pwsf_pkg::REG_W-1:0] fixed_wl[12];
    logic [pwsf_pkg::REG_W-1:0] fixed_mn[12];
    logic [pwsf_pkg::REG_W-1:0] wl;
    logic [pwsf_pkg::REG_W-1:0] mn;
    int i;

    // extremes and corner settings: clamped lengths, zero minimum,
    // minimum above the window, full-length window
    fixed_wl = '{7'd3, 7'd3, 7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd65, 7'd127, 7'd64, 7'd8, 7'd16};
    fixed_mn = '{7'd0, 7'd3, 7'd2, 7'd3, 7'd1, 7'd64, 7'd50, 7'd64, 7'd127, 7'd0, 7'd9, 7'd12};

    // directed rows under the reset settings (window 16, minimum 12)
    // lone base right after reset: too short for a window
    add_row(pwsf_pkg::T_CHAR, 16'd0, 1'b1, 1'b1, 1'b0, '0);
    // extreme field values in a short stream
    add_row(8'hFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 16'h0000, 1'b1, 1'b1, 1'b0, '0);
    // sixteen ts across the index wrap: run ends just before 9 - 15 + 3, modulo 2^17
    for (i = 0; i < 16; i++)
      add_row(pwsf_pkg::T_CHAR, pwsf_pkg::IDX_W'(16'hFFFA + i), i == 15, 1'b1, 1'b1,
              17'h1FFFD);
    // lowercase t never counts
    add_row(CH_T_LOWER, 16'd7, 1'b0, 1'b0, 1'b0, '0);
    add_row(pwsf_pkg::T_CHAR, 16'd8, 1'b0, 1'b0, 1'b0, '0);
    add_row(CH_A, 16'd9, 1'b1, 1'b0, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[n])
      send_base(directed[n].base, directed[n].idx, directed[n].last,
                directed[n].typed, directed[n].found, directed[n].pos);

    for (i = 0; i < 12; i++) begin
      set_registers(fixed_wl[i], fixed_mn[i]);
      run_phase();
    end

    // random settings, mostly small windows with reachable minimums
    while (sent_bases < ITEM_TARGET) begin
      wl = ($urandom_range(0, 5) == 0) ? pwsf_pkg::REG_W'($urandom_range(0, 127))
                                       : pwsf_pkg::REG_W'($urandom_range(3, 24));
      mn = ($urandom_range(0, 5) == 0) ? pwsf_pkg::REG_W'($urandom_range(0, 127))
                                       : pwsf_pkg::REG_W'($urandom_range(0, span_of(wl)));
      set_registers(wl, mn);
      run_phase();
    end

    in_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (faults == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
hdl/pwsf_pkg.sv
hdl/pwsf_front.sv
hdl/pwsf_queue.sv
hdl/pwsf_back.sv
hdl/polyt_window_start_finder.sv
verif/testbench.sv
